@@ rtl/ltc_pkg.sv @@
// ----------------------------------------------------------------------------
// ltc_pkg: shared types and constants of the 4-way LRU tag cache core
// Geometry, field widths, operation codes, sequencer states and the
// control/status structs passed between the sequencer and the compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ltc_pkg;

  // SETS must be a power of two: the set is taken from the low index bits.
  localparam int SETS       = 512;
  localparam int WAYS       = 4;
  localparam int WAY_W      = $clog2(WAYS);
  localparam int SET_W      = $clog2(SETS);
  localparam int LINES      = SETS * WAYS;
  localparam int LINE_W     = SET_W + WAY_W;
  localparam int TAG_W      = 31;
  localparam int STAMP_W    = 32;
  localparam int LINE_IDX_W = 11;

  localparam logic OP_FETCH = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_LAST,
    ST_WRITE
  } ltc_state_t;

  typedef struct packed {
    logic             step;
    logic             first;
    logic [WAY_W-1:0] way;
  } cmp_ctl_t;

  typedef struct packed {
    logic             found;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] vic_way;
    logic             vic_live;
    logic [TAG_W-1:0] vic_tag;
  } cmp_res_t;

endpackage

`default_nettype wire

@@ rtl/ltc_ram.sv @@
// ----------------------------------------------------------------------------
// ltc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/ltc_cmp.sv @@
// ----------------------------------------------------------------------------
// ltc_cmp: shared tag/stamp compare unit
// Takes one way per step: checks for a valid tag match and tracks the
// oldest stamp (ties to the lower way) together with its tag.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_cmp
  import ltc_pkg::*;
(
  input  wire logic               clk,
  input  wire cmp_ctl_t           ctl,
  input  wire logic [TAG_W-1:0]   vox,
  input  wire logic [TAG_W-1:0]   tag,
  input  wire logic [STAMP_W-1:0] stamp,
  output cmp_res_t                res
);

  cmp_res_t           res_r, res_nxt;
  logic [STAMP_W-1:0] oldest_r, oldest_nxt;
  logic               match;

  assign match = (stamp != '0) && (tag == vox);

  always_comb begin
    res_nxt    = res_r;
    oldest_nxt = oldest_r;
    if (ctl.step) begin
      if (ctl.first) begin
        res_nxt.found   = match;
        res_nxt.hit_way = ctl.way;
        res_nxt.vic_way = ctl.way;
        res_nxt.vic_tag = tag;
        oldest_nxt      = stamp;
      end else begin
        // later matching way wins
        if (match) begin
          res_nxt.found   = 1'b1;
          res_nxt.hit_way = ctl.way;
        end
        if (stamp < oldest_r) begin
          res_nxt.vic_way = ctl.way;
          res_nxt.vic_tag = tag;
          oldest_nxt      = stamp;
        end
      end
    end
    res_nxt.vic_live = (oldest_nxt != '0);
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    oldest_r <= oldest_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

@@ rtl/four_way_lru_tag_cache_core.sv @@
// Fetch sequence: accept, four way reads through the shared compare unit, a
// final compare, then the update, from which out_valid is registered; busy
// stays high until the update is done. A flush reports next cycle and then
// walks the stamp RAM one line per cycle.
// Reset: synchronous; the same stamp clear runs after reset.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// four_way_lru_tag_cache_core: 4-way set-associative tag/LRU engine
// Sequencer reads the four ways of a set through one compare unit, picks the
// hit or the oldest way, writes back its timestamp and, on a miss, its tag.
// ----------------------------------------------------------------------------
`default_nettype none

module four_way_lru_tag_cache_core
  import ltc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_op,
  input  wire logic [TAG_W-1:0]      in_voxel_index,
  output logic                       out_valid,
  output logic [LINE_IDX_W-1:0]      out_line_index,
  output logic                       out_hit,
  output logic                       out_victim_valid,
  output logic [TAG_W-1:0]           out_victim_voxel
);

  ltc_state_t          state_r, state_nxt;
  logic [TAG_W-1:0]    vox_r;
  logic [WAY_W-1:0]    rd_way_r;
  logic                cmp_vld_r;
  logic [WAY_W-1:0]    cmp_way_r;
  logic [LINE_W-1:0]   clr_cnt_r;
  logic [STAMP_W-1:0]  use_clock_r, use_clock_inc;

  logic                out_valid_r;
  logic [LINE_IDX_W-1:0] out_line_r;
  logic                out_hit_r, out_vv_r;
  logic [TAG_W-1:0]    out_vvox_r;

  logic [SET_W-1:0]    set_idx;
  logic [WAY_W-1:0]    sel_way;
  logic [LINE_W-1:0]   wr_line;
  logic                accept;

  logic                tag_we, stamp_we;
  logic [LINE_W-1:0]   raddr, stamp_waddr;
  logic [STAMP_W-1:0]  stamp_wdata;
  logic [TAG_W-1:0]    tag_rdata;
  logic [STAMP_W-1:0]  stamp_rdata;

  cmp_ctl_t            cmp_ctl;
  cmp_res_t            cmp_res;

  assign set_idx = vox_r[SET_W-1:0];
  assign sel_way = cmp_res.found ? cmp_res.hit_way : cmp_res.vic_way;
  assign wr_line = {set_idx, sel_way};
  assign accept  = start && !busy;
  assign use_clock_inc = use_clock_r + STAMP_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LINE_W'(LINES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = (in_op == OP_FLUSH) ? ST_CLEAR : ST_LOOK;
      end
      ST_LOOK: begin
        if (rd_way_r == WAY_W'(WAYS - 1)) state_nxt = ST_LAST;
      end
      ST_LAST:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy        = 1'b1;
    tag_we      = 1'b0;
    stamp_we    = 1'b0;
    raddr       = {set_idx, rd_way_r};
    stamp_waddr = wr_line;
    stamp_wdata = use_clock_r;
    case (state_r)
      ST_CLEAR: begin
        stamp_we    = 1'b1;
        stamp_waddr = clr_cnt_r;
        stamp_wdata = '0;
      end
      ST_IDLE: busy = 1'b0;
      ST_WRITE: begin
        stamp_we = 1'b1;
        tag_we   = !cmp_res.found;
      end
      default: ;
    endcase
  end

  assign cmp_ctl.step  = cmp_vld_r;
  assign cmp_ctl.first = (cmp_way_r == '0);
  assign cmp_ctl.way   = cmp_way_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      use_clock_r <= STAMP_W'(1);
      cmp_vld_r   <= 1'b0;
      rd_way_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= (state_r == ST_LOOK);
      cmp_way_r   <= rd_way_r;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + LINE_W'(1);
      if (state_r == ST_LOOK)  rd_way_r  <= rd_way_r + WAY_W'(1);
      if (accept) begin
        vox_r    <= in_voxel_index;
        rd_way_r <= '0;
        if (in_op == OP_FLUSH) begin
          clr_cnt_r   <= '0;
          use_clock_r <= STAMP_W'(1);
          out_valid_r <= 1'b1;
          out_line_r  <= '0;
          out_hit_r   <= 1'b0;
          out_vv_r    <= 1'b0;
          out_vvox_r  <= '0;
        end
      end
      if (state_r == ST_WRITE) begin
        // clock skips zero so a stamp of zero always means invalid
        use_clock_r <= (use_clock_inc == '0) ? STAMP_W'(1) : use_clock_inc;
        out_valid_r <= 1'b1;
        out_line_r  <= LINE_IDX_W'(wr_line);
        out_hit_r   <= cmp_res.found;
        out_vv_r    <= !cmp_res.found && cmp_res.vic_live;
        out_vvox_r  <= (!cmp_res.found && cmp_res.vic_live) ? cmp_res.vic_tag : '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_index   = out_line_r;
  assign out_hit          = out_hit_r;
  assign out_victim_valid = out_vv_r;
  assign out_victim_voxel = out_vvox_r;

  ltc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (wr_line),
    .wdata (vox_r),
    .raddr (raddr),
    .rdata (tag_rdata)
  );

  ltc_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (LINES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (stamp_wdata),
    .raddr (raddr),
    .rdata (stamp_rdata)
  );

  ltc_cmp u_cmp (
    .clk   (clk),
    .ctl   (cmp_ctl),
    .vox   (vox_r),
    .tag   (tag_rdata),
    .stamp (stamp_rdata),
    .res   (cmp_res)
  );

`ifndef ASSERT_OFF
  a_clock_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    use_clock_r != '0) else $error("use clock reached zero");

  a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_victim_valid) else $error("victim reported on hit");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("not busy after accept");

  a_write_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |=> out_valid) else $error("missing result strobe");
`endif

endmodule

`default_nettype wire
